// File: design/slfr_pkg.sv
package slfr_pkg;

    // crc-8 generator polynomial, msb first
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // length byte counts the type and crc bytes on top of the payload
    localparam logic [6:0] LEN_OVERHEAD = 7'd2;

    // frame status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;

    // one result item
    typedef struct packed {
        logic        strobe;
        logic [7:0]  pbyte;
        logic [5:0]  pidx;
        logic        done;
        logic [1:0]  status;
        logic [7:0]  ftype;
        logic [5:0]  plen;
        logic [7:0]  crc_rx;
        logic [7:0]  crc_comp;
        logic [31:0] good;
        logic [31:0] bad;
    } t_result;

    // one byte through the crc-8 register, msb first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: design/sync_length_frame_receiver_crc8.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------
// input    | i_in_valid   | o_in_stall   | i_rx_byte
// output   | o_out_valid  | i_out_stall  | o_payload_* o_frame_* o_crc_* counters
// config   | i_cfg_we     | (none)       | i_cfg_data (sync address)
//
// one item per cycle while the output is not stalled; each item passes an input
// register, the parser logic with its one-byte crc update, and the result register
// reset is synchronous, active low; the parser starts hunting, sync address 0xc8
// a stalled output holds its item while the input register still takes one more;
// o_in_stall rises only when both registers are full and the output is stalled
module sync_length_frame_receiver_crc8 #(
    parameter int MAX_PAYLOAD = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_payload_strobe,
    output logic [7:0]  o_payload_byte,
    output logic [5:0]  o_payload_index,
    output logic        o_frame_done,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_type,
    output logic [5:0]  o_payload_length,
    output logic [7:0]  o_crc_received,
    output logic [7:0]  o_crc_computed,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    slfr_pkg::t_result r_res;
    slfr_pkg::t_result res;
    logic [7:0]        r_sync;
    logic              out_free;
    logic              fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // sync address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 8'hC8;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slfr_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_byte         (r_in_byte),
        .i_sync_address (r_sync),
        .o_res          (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_strobe = r_res.strobe;
    assign o_payload_byte   = r_res.pbyte;
    assign o_payload_index  = r_res.pidx;
    assign o_frame_done     = r_res.done;
    assign o_frame_status   = r_res.status;
    assign o_frame_type     = r_res.ftype;
    assign o_payload_length = r_res.plen;
    assign o_crc_received   = r_res.crc_rx;
    assign o_crc_computed   = r_res.crc_comp;
    assign o_good_frames    = r_res.good;
    assign o_bad_frames     = r_res.bad;

    // an item never moves into a result register that still holds a stalled item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // a valid result item is never shown as done and strobe at once
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.done && r_res.strobe))
        else $error("payload strobe on crc byte");

    // a stalled result item stays put until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_res))
        else $error("stalled result item changed");

endmodule

// File: design/slfr_core.sv
module slfr_core #(
    parameter int MAX_PAYLOAD = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_sync_address,
    output slfr_pkg::t_result     o_res
);

    localparam logic [7:0] LenMax = 8'(MAX_PAYLOAD + 2);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]  r_phase,     n_phase;
    logic [6:0]  r_left,      n_left;
    logic [6:0]  r_len,       n_len;
    logic [6:0]  r_pos,       n_pos;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_crc,       n_crc;
    logic [31:0] r_good,      n_good;
    logic [31:0] r_bad,       n_bad;
    logic [6:0]  left_dec;

    assign left_dec = r_left - 7'd1;

    // frame parser, one byte per item
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_len   = r_len;
        n_pos   = r_pos;
        n_type  = r_type;
        n_crc   = r_crc;
        n_good  = r_good;
        n_bad   = r_bad;
        o_res   = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_sync_address) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_byte < 8'(slfr_pkg::LEN_OVERHEAD) || i_byte > LenMax) begin
                    n_phase = PH_HUNT;
                    n_left  = '0;
                    n_pos   = '0;
                end else begin
                    n_len   = i_byte[6:0];
                    n_left  = i_byte[6:0];
                    n_pos   = '0;
                    n_crc   = '0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_pos == 7'd0) begin
                    n_type = i_byte;
                end
                o_res.ftype = (r_pos == 7'd0) ? i_byte : r_type;
                o_res.plen  = 6'(r_len - slfr_pkg::LEN_OVERHEAD);
                n_left      = left_dec;
                if (left_dec == 7'd0) begin
                    // crc byte closes the frame
                    o_res.done     = 1'b1;
                    o_res.crc_rx   = i_byte;
                    o_res.crc_comp = r_crc;
                    if (i_byte == r_crc) begin
                        o_res.status = slfr_pkg::ST_OK;
                        n_good       = r_good + 32'd1;
                    end else begin
                        o_res.status = slfr_pkg::ST_CRC_ERR;
                        n_bad        = r_bad + 32'd1;
                    end
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                end else begin
                    n_crc = slfr_pkg::crc_feed(r_crc, i_byte);
                    if (r_pos != 7'd0) begin
                        o_res.strobe = 1'b1;
                        o_res.pbyte  = i_byte;
                        o_res.pidx   = 6'(r_pos - 7'd1);
                    end
                    n_pos = r_pos + 7'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_left  = '0;
                n_pos   = '0;
            end
        endcase
        o_res.good = n_good;
        o_res.bad  = n_bad;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_type  <= '0;
            r_crc   <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

    // body bytes taken plus bytes left always add up to the length field
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> (r_left + r_pos) == r_len)
        else $error("body position and bytes left disagree with length");

    // a good frame bumps the good counter by exactly one
    a_good_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.done && o_res.status == slfr_pkg::ST_OK
        |=> r_good == $past(r_good) + 32'd1)
        else $error("good frame counter not bumped");

    // a bad frame leaves the good counter alone and bumps the bad counter by one
    a_bad_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.done && o_res.status == slfr_pkg::ST_CRC_ERR
        |=> r_good == $past(r_good) && r_bad == $past(r_bad) + 32'd1)
        else $error("bad frame counters wrong");

endmodule
